@@ rtl/core/utfdec_pkg.sv @@
// shared types and constants of the utf-8 to ucs-2 field decoder
package utfdec_pkg;

  localparam int CFG_W     = 7;
  localparam int CMD_CNT_W = 9;  // holds a fill run of up to 511 symbols

  localparam logic [CFG_W-1:0] SYMBOL_COUNT_RESET = 7'd16;

  localparam logic [7:0]  DASH_CHAR      = 8'h2D;
  localparam logic [15:0] UNDERSCORE_SYM = 16'h005F;
  localparam logic [15:0] SPACE_SYM      = 16'h0020;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] symbol;
    logic        field_last;
  } sym_item_t;

  // one decoded symbol and how many outputs it stands for
  typedef struct packed {
    logic [15:0]          symbol;
    logic [CMD_CNT_W-1:0] count;
    logic                 last;
  } cmd_t;

endpackage

@@ rtl/core/utfdec_front.sv @@
// front end: takes bytes, decodes utf-8 and issues symbol commands
module utfdec_front #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  output logic                       byte_ready,
  input  utfdec_pkg::byte_item_t     byte_item,
  input  logic [utfdec_pkg::CFG_W-1:0] symbol_count,
  output logic                       push,
  output utfdec_pkg::cmd_t           cmd,
  input  logic                       q_ready
);
  import utfdec_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CNT_W-1:0] symbols_left, left_next;
  logic [15:0]      partial_code, partial_next;
  logic [1:0]       bytes_pending, pending_next;
  logic             dash_held, dash_next;
  logic             field_done, done_next;

  logic [CMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0] start_cnt;
  logic [7:0]       c;
  logic             dash_emit;

  assign c       = byte_item.text_byte;
  assign cfg_ext = CMP_W'(symbol_count);
  assign start_cnt = (cfg_ext > CMP_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS) : CNT_W'(cfg_ext);

  // held dash followed by a real byte: dash goes out first, byte waits until it is pushed
  assign dash_emit  = byte_valid && !byte_item.string_start && !field_done &&
                      dash_held && (c != 8'd0);
  assign byte_ready = q_ready && !dash_emit;

  always_comb begin
    logic [CNT_W-1:0] work_left;
    logic [15:0]      work_partial;
    logic [1:0]       work_pending;
    logic             decode;
    logic             have_sym;
    logic [15:0]      sym;

    left_next    = symbols_left;
    partial_next = partial_code;
    pending_next = bytes_pending;
    dash_next    = dash_held;
    done_next    = field_done;
    push         = 1'b0;
    cmd          = '0;
    work_left    = symbols_left;
    work_partial = partial_code;
    work_pending = bytes_pending;
    decode       = 1'b0;
    have_sym     = 1'b0;
    sym          = '0;

    if (dash_emit) begin
      if (q_ready) begin
        push       = 1'b1;
        cmd.symbol = {8'd0, DASH_CHAR};
        cmd.count  = CMD_CNT_W'(1);
        cmd.last   = (symbols_left == CNT_W'(1));
        left_next  = symbols_left - CNT_W'(1);
        done_next  = (symbols_left == CNT_W'(1));
        dash_next  = 1'b0;
      end
    end else if (byte_valid && q_ready) begin
      if (byte_item.string_start) begin
        // new string abandons whatever was in flight
        left_next    = start_cnt;
        partial_next = '0;
        pending_next = PEND_NONE;
        dash_next    = 1'b0;
        done_next    = (start_cnt == '0);
        work_left    = start_cnt;
        work_partial = '0;
        work_pending = PEND_NONE;
        if (start_cnt != '0) begin
          if (c == DASH_CHAR) begin
            dash_next = 1'b1;
          end else begin
            decode = 1'b1;
          end
        end
      end else if (!field_done) begin
        dash_next = 1'b0;
        decode    = 1'b1;
      end
    end

    if (decode) begin
      case (work_pending)
        PEND_TWO: begin
          partial_next = work_partial | {4'd0, c[5:0], 6'd0};
          pending_next = PEND_ONE;
        end
        PEND_ONE: begin
          sym          = work_partial | {10'd0, c[5:0]};
          have_sym     = 1'b1;
          pending_next = PEND_NONE;
        end
        default: begin
          if (!c[7]) begin
            sym      = {8'd0, c};
            have_sym = 1'b1;
          end else if (!c[5]) begin
            partial_next = {5'd0, c[4:0], 6'd0};
            pending_next = PEND_ONE;
          end else begin
            partial_next = {c[3:0], 12'd0};
            pending_next = PEND_TWO;
          end
        end
      endcase
    end

    if (have_sym) begin
      if (sym == UNDERSCORE_SYM) begin
        sym = SPACE_SYM;
      end
      push       = 1'b1;
      cmd.symbol = sym;
      if (sym == 16'd0) begin
        // terminator: this symbol plus zero fill to the end of the field
        cmd.count = CMD_CNT_W'(work_left);
        cmd.last  = 1'b1;
        left_next = '0;
        done_next = 1'b1;
      end else begin
        cmd.count = CMD_CNT_W'(1);
        cmd.last  = (work_left == CNT_W'(1));
        left_next = work_left - CNT_W'(1);
        done_next = (work_left == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_left  <= '0;
      partial_code  <= '0;
      bytes_pending <= PEND_NONE;
      dash_held     <= 1'b0;
      field_done    <= 1'b1;
    end else begin
      symbols_left  <= left_next;
      partial_code  <= partial_next;
      bytes_pending <= pending_next;
      dash_held     <= dash_next;
      field_done    <= done_next;
    end
  end

endmodule

@@ rtl/core/utfdec_queue.sv @@
// two-entry command queue between front and back end
module utfdec_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utfdec_pkg::cmd_t push_cmd,
  output logic             q_ready,
  output logic             q_valid,
  output utfdec_pkg::cmd_t head_cmd,
  input  logic             pop
);
  import utfdec_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign q_ready  = (fill != 2'(DEPTH));
  assign q_valid  = (fill != 2'd0);
  assign head_cmd = entries[rd_ptr];
  assign do_push  = push && q_ready;
  assign do_pop   = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/core/utfdec_back.sv @@
// back end: expands commands into output symbols, zero fill included
module utfdec_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  utfdec_pkg::cmd_t      head_cmd,
  output logic                  pop,
  output logic                  sym_valid,
  input  logic                  sym_ready,
  output utfdec_pkg::sym_item_t sym_item
);
  import utfdec_pkg::*;

  cmd_t                 cur;
  logic [CMD_CNT_W-1:0] remaining;
  logic                 busy;
  logic                 finishing;

  // a zero fill repeats the zero symbol, so the symbol field stays as loaded
  assign sym_valid           = busy;
  assign sym_item.symbol     = cur.symbol;
  assign sym_item.field_last = cur.last && (remaining == CMD_CNT_W'(1));

  assign finishing = busy && sym_ready && (remaining == CMD_CNT_W'(1));
  assign pop       = q_valid && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      remaining <= head_cmd.count;
    end else if (busy && sym_ready) begin
      remaining <= remaining - CMD_CNT_W'(1);
      if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/utf8_to_ucs2_field_decoder.sv @@
// top level of the utf-8 to ucs-2 field decoder
//
// byte channel (byte_valid/byte_ready/byte_item) takes one utf-8 byte per item;
// string_start marks the first byte of a string and restarts decoding
// symbol channel (sym_valid/sym_ready/sym_item) gives symbol_count ucs-2 symbols
// per string not abandoned by a new start, field_last set on the final one
// cfg channel (cfg_valid/cfg_ready/cfg_data) writes symbol_count, always ready;
// the value is sampled at each string start and saturated to MAX_SYMBOLS
// a completed symbol goes through the command queue and the back end's output
// register to sym_item; throughput: one byte per cycle while the queue has room;
// a byte after a held leading dash waits while the dash is pushed; a terminator
// expands into a zero fill of one symbol per cycle in the back end while sym_ready
// is high, while the front keeps taking bytes until the two-entry queue is full
// receiver stall: the back end holds its symbol, the queue fills, then
// byte_ready drops
// reset: symbol_count returns to 16, queue empties, decoder idles until a start
module utf8_to_ucs2_field_decoder #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  utfdec_pkg::byte_item_t       byte_item,
  output logic                         sym_valid,
  input  logic                         sym_ready,
  output utfdec_pkg::sym_item_t        sym_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [utfdec_pkg::CFG_W-1:0] cfg_data
);
  import utfdec_pkg::*;

  logic [CFG_W-1:0] symbol_count;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_ready;

  // queue to back
  logic q_valid;
  cmd_t head_cmd;
  logic pop;

  // config register, written by the user only while the block is idle; unchecked
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= SYMBOL_COUNT_RESET;
    end else if (cfg_valid) begin
      symbol_count <= cfg_data;
    end
  end

  // decode bytes and track the field position
  utfdec_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .symbol_count (symbol_count),
    .push         (push),
    .cmd          (push_cmd),
    .q_ready      (q_ready)
  );

  // lets decoding run ahead of a stalled or filling output
  utfdec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .head_cmd (head_cmd),
    .pop      (pop)
  );

  // output register and zero fill counter
  utfdec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym_item  (sym_item)
  );

endmodule

@@ tb/ucs2_field_board_pkg.sv @@
// expected-symbol bookkeeping and checking for the utf-8 to ucs-2 field decoder
`timescale 1ns / 1ps

package ucs2_field_board_pkg;

  import utfdec_pkg::*;

  class ucs2_field_board;
    int unsigned      max_symbols;
    logic [CFG_W-1:0] symbol_count;

    // decoder state as it should be after each item
    bit [6:0]  symbols_owed;
    bit [15:0] code_acc;
    bit [1:0]  cont_owed;
    bit        dash_waiting;
    bit        idle;

    sym_item_t   expected_syms[$];
    int unsigned mismatches;
    int unsigned symbols_checked;
    int unsigned fields_closed;
    int unsigned strings_started;

    function new(int unsigned max_symbols);
      this.max_symbols = max_symbols;
      symbol_count     = SYMBOL_COUNT_RESET;
      symbols_owed     = '0;
      code_acc         = '0;
      cont_owed        = PEND_NONE;
      dash_waiting     = 1'b0;
      idle             = 1'b1;
      mismatches       = 0;
      symbols_checked  = 0;
      fields_closed    = 0;
      strings_started  = 0;
    endfunction

    // one symbol into the field; a zero symbol also pads out the rest
    function void emit(bit [15:0] sym);
      sym_item_t e;
      if (sym == UNDERSCORE_SYM) sym = SPACE_SYM;
      symbols_owed--;
      e.symbol     = sym;
      e.field_last = (symbols_owed == 0);
      expected_syms.push_back(e);
      if (sym == 16'h0000) begin
        while (symbols_owed != 0) begin
          symbols_owed--;
          e.symbol     = 16'h0000;
          e.field_last = (symbols_owed == 0);
          expected_syms.push_back(e);
        end
      end
      if (symbols_owed == 0) idle = 1'b1;
    endfunction

    function void decode(bit [7:0] c);
      case (cont_owed)
        PEND_TWO: begin
          code_acc  = code_acc | {4'h0, c[5:0], 6'h00};
          cont_owed = PEND_ONE;
        end
        PEND_ONE: begin
          code_acc  = code_acc | {10'h000, c[5:0]};
          cont_owed = PEND_NONE;
          emit(code_acc);
        end
        default: begin
          if (!c[7]) begin
            emit({8'h00, c});
          end else if (!c[5]) begin
            code_acc  = {5'h00, c[4:0], 6'h00};
            cont_owed = PEND_ONE;
          end else begin
            code_acc  = {c[3:0], 12'h000};
            cont_owed = PEND_TWO;
          end
        end
      endcase
    endfunction

    // returns 1 when the byte is taken by the decoder, 0 when it is ignored
    function bit note_byte(byte_item_t it);
      int unsigned len;
      if (it.string_start) begin
        len          = (symbol_count > max_symbols) ? max_symbols : symbol_count;
        symbols_owed = 7'(len);
        code_acc     = '0;
        cont_owed    = PEND_NONE;
        dash_waiting = 1'b0;
        idle         = (len == 0);
        if (idle) return 1'b0;
        strings_started++;
        if (it.text_byte == DASH_CHAR) begin
          dash_waiting = 1'b1;
          return 1'b1;
        end
        decode(it.text_byte);
        return 1'b1;
      end
      if (idle) return 1'b0;
      if (dash_waiting) begin
        dash_waiting = 1'b0;
        if (it.text_byte != 8'h00) begin
          emit({8'h00, DASH_CHAR});
          if (idle) return 1'b1;
        end
      end
      decode(it.text_byte);
      return 1'b1;
    endfunction

    function void check_symbol(sym_item_t got);
      sym_item_t want;
      if (expected_syms.size() == 0) begin
        $error("unexpected symbol item: symbol %h field_last %0d", got.symbol, got.field_last);
        mismatches++;
        return;
      end
      want = expected_syms.pop_front();
      symbols_checked++;
      if (got.field_last === 1'b1) fields_closed++;
      if (got.symbol !== want.symbol) begin
        $error("symbol: expected %h, got %h", want.symbol, got.symbol);
        mismatches++;
      end
      if (got.field_last !== want.field_last) begin
        $error("field_last: expected %0d, got %0d", want.field_last, got.field_last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
// top-level testbench of the utf-8 to ucs-2 field decoder
`timescale 1ns / 1ps

module tb_top;

  import utfdec_pkg::*;
  import ucs2_field_board_pkg::*;

  localparam int MAX_SYMBOLS = 64;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 36;  // at least this many bytes sent per phase with a nonempty field
  localparam int SETTLE      = 10;  // cycles to let the pipeline empty out
  localparam int LONG_HOLD   = 400;

  // who idles during a phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic             clk;
  logic             rst        = 1'b1;
  logic             byte_valid = 1'b0;
  logic             byte_ready;
  byte_item_t       byte_item  = '0;
  logic             sym_valid;
  logic             sym_ready  = 1'b0;
  sym_item_t        sym_item;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data   = '0;

  ucs2_field_board board;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned bytes_taken  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned hold_req     = 0;  // long receiver hold asked by the sender side
  int unsigned hold_left    = 0;

  utf8_to_ucs2_field_decoder #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym_item  (sym_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: check each symbol item, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && sym_valid && sym_ready) board.check_symbol(sym_item);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      // long hold-off so the command queue fills and byte_ready drops
      hold_left--;
      sym_ready <= 1'b0;
    end else begin
      sym_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void set_idle_mode(idle_mode_t m);
    case (m)
      IDLE_SENDER: begin
        tx_idle_pct  = 63;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 63;
      end
      IDLE_BOTH: begin
        tx_idle_pct  = 29;
        rx_stall_pct = 29;
      end
      default: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
    endcase
  endfunction

  // one byte item; valid stays up across back-to-back items
  task automatic send_byte(input logic [7:0] b, input logic first);
    byte_item_t it;
    if ($urandom_range(99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    it.text_byte    = b;
    it.string_start = first;
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    if (board.note_byte(it)) bytes_taken++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == 0);
  endtask

  // hold the sender until every expected symbol has arrived
  task automatic drain_symbols();
    byte_valid <= 1'b0;
    do @(posedge clk); while (board.expected_syms.size() != 0);
  endtask

  // the config write only happens with the decoder fully drained
  task automatic write_symbol_count(input logic [CFG_W-1:0] v);
    drain_symbols();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.symbol_count = v;
  endtask

  // continuation byte; mostly well formed, the top bits are never checked
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 85) return {2'b10, 6'($urandom)};
    return 8'($urandom);
  endfunction

  task automatic send_random_string();
    logic [7:0]  s[$];
    logic [7:0]  b;
    int unsigned kind;
    int unsigned nsym;
    int unsigned field_len;
    kind      = $urandom_range(99);
    field_len = (board.symbol_count > MAX_SYMBOLS) ? MAX_SYMBOLS : board.symbol_count;
    if (kind < 10) begin
      // lone dash gives an all-zero field
      s = '{DASH_CHAR, 8'h00};
    end else if (kind < 25) begin
      // noise: raw bytes with starts scattered in
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(99) < 20);
      return;
    end else begin
      if ($urandom_range(9) == 0) s.push_back(DASH_CHAR);
      // mostly short strings, now and then longer than the field
      nsym = ($urandom_range(99) < 15) ? $urandom_range(field_len + 2) : $urandom_range(10);
      repeat (nsym) begin
        case ($urandom_range(2))
          0: begin
            b = 8'($urandom_range(127, 1));
            if ($urandom_range(9) == 0) b = UNDERSCORE_SYM[7:0];
            s.push_back(b);
          end
          1: begin
            // any lead with bit 7 set and bit 5 clear
            s.push_back(8'h80 | (8'($urandom) & 8'hDF));
            s.push_back(cont_byte());
          end
          default: begin
            // any lead with bits 7 and 5 set
            s.push_back(8'hA0 | 8'($urandom));
            s.push_back(cont_byte());
            s.push_back(cont_byte());
          end
        endcase
      end
      // unterminated strings get abandoned by the next start
      if ($urandom_range(99) < 85) s.push_back(8'h00);
    end
    if (s.size() == 0) s.push_back(8'h00);
    send_string(s);
  endtask

  task automatic run_items(input int unsigned n);
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent - first < n) send_random_string();
  endtask

  initial begin
    logic [7:0]       q[$];
    logic [CFG_W-1:0] field_sizes[PHASES];
    board = new(MAX_SYMBOLS);
    // phase 0 runs at the reset size; the rest hit the extremes and saturation
    field_sizes = '{SYMBOL_COUNT_RESET, 7'd1, 7'd64, 7'd127, 7'd0, 7'd3,
                    7'($urandom_range(63, 2)), 7'd5};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset field size, no idling
    send_byte(8'hFF, 1'b0);                 // stray byte while idle, ignored
    q = '{DASH_CHAR, 8'h00};                // lone dash: all-zero field
    send_string(q);
    q = '{DASH_CHAR, 8'h41, 8'h00};         // dash released ahead of a letter
    send_string(q);
    // underscore, two-byte, three-byte max, two-byte underscore, terminator
    q = '{8'h5F, 8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF, 8'hC1, 8'h9F, 8'h00};
    send_string(q);
    q = '{8'hE0, 8'h80, 8'h80};             // multi-byte symbol decoding to zero
    send_string(q);
    send_byte(8'h41, 1'b1);                 // abandoned by the next start
    q = '{8'h42, 8'h00};
    send_string(q);
    send_byte(DASH_CHAR, 1'b1);             // held dash abandoned, emits nothing
    q = '{8'h43, 8'hC3, 8'h00, 8'h00};      // nul taken as continuation data
    send_string(q);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) write_symbol_count(field_sizes[p]);
      set_idle_mode(idle_mode_t'(p % 4));
      if (field_sizes[p] == 0) begin
        // empty field: every byte is ignored, so count strings instead
        repeat (6) send_random_string();
      end else begin
        run_items(PHASE_ITEMS / 2);
        if (p == 2) hold_req = LONG_HOLD;   // receiver goes quiet, sender keeps going
        if (p == 5) drain_symbols();        // sender waits for the output to catch up
        run_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      end
    end

    drain_symbols();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d bytes sent, %0d decoded, over %0d strings",
             bytes_sent, bytes_taken, board.strings_started);
    $display("%0d symbols in %0d fields checked; field sizes 0 to 127, stalls, one long hold",
             board.symbols_checked, board.fields_closed);
    if (board.mismatches == 0 && board.expected_syms.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
